[rtl/sector_cache_clock_replacement_defines.svh]
// Assertion macros for the sector cache with clock replacement.
// Included by files that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SCC_ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold whenever a precondition holds.
`define SCC_ASSERT_IMPLY(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

[rtl/scc_pkg.sv]
// Package for the sector cache with clock replacement: beat types, codes, state encoding.
// No dependencies; used by the entry evaluation unit and the top level.
package scc_pkg;

	localparam int SECTOR_W = 32;
	localparam int PIN_W    = 8;
	localparam int SLOT_W   = 6;

	localparam logic [PIN_W-1:0] PIN_MAX = '1;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_FLUSH   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_VICTIM = 2'd1,
		STAT_ABSENT    = 2'd2
	} stat_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [SECTOR_W-1:0] sector;
		logic                mark_dirty;
		logic                invalidate_all;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic                hit;
		logic                fetch_needed;
		logic                writeback_valid;
		logic [SECTOR_W-1:0] writeback_sector;
		logic [1:0]          status;
		logic                last;
	} rsp_t;

	// One cache entry as it sits in the entry memory.
	typedef struct packed {
		logic [SECTOR_W-1:0] tag;
		logic [PIN_W-1:0]    pin;
		logic                dirty;
		logic                acc;
	} entry_t;

	// Everything the sequencer needs to know about one entry read back.
	typedef struct packed {
		logic   tag_eq;
		logic   pinned;
		entry_t get_hit;
		entry_t unpin;
		entry_t acc_clr;
		entry_t dirty_clr;
		entry_t fresh;
	} eval_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_CLOCK,
		S_RESP,
		S_FL_RD,
		S_FL_EV,
		S_FL_END
	} fsm_t;

endpackage

[rtl/scc_stream_if.sv]
// Valid/ready stream interface used for the request and result channels.
// The payload type is given per instance; no other dependencies.
interface scc_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

[rtl/scc_entry_eval.sv]
// Shared evaluation unit: compares one entry read from memory and forms its updated words.
// Depends on scc_pkg for entry_t and eval_t.
module scc_entry_eval import scc_pkg::*; (
	input  entry_t              entry,
	input  logic [SECTOR_W-1:0] sector,
	input  logic                mark_dirty,
	output eval_t               ev
);

	always_comb begin
		ev.tag_eq = (entry.tag == sector);
		ev.pinned = (entry.pin != '0);

		// Pin counts saturate at the top instead of wrapping.
		ev.get_hit       = entry;
		ev.get_hit.pin   = (entry.pin == PIN_MAX) ? entry.pin : entry.pin + PIN_W'(1);
		ev.get_hit.dirty = entry.dirty | mark_dirty;
		ev.get_hit.acc   = 1'b1;

		ev.unpin     = entry;
		ev.unpin.pin = ev.pinned ? entry.pin - PIN_W'(1) : entry.pin;

		ev.acc_clr     = entry;
		ev.acc_clr.acc = 1'b0;

		ev.dirty_clr       = entry;
		ev.dirty_clr.dirty = 1'b0;

		ev.fresh.tag   = sector;
		ev.fresh.pin   = PIN_W'(1);
		ev.fresh.dirty = mark_dirty;
		ev.fresh.acc   = 1'b1;
	end

endmodule

[rtl/sector_cache_clock_replacement.sv]
// Top level of the sector cache with clock replacement: sequencer, entry memory, result register.
// Depends on scc_pkg, scc_stream_if, scc_entry_eval and the assertion macro header.
//
// Usage: requests arrive on req (command, sector, mark_dirty, invalidate_all), results
// leave on rsp. One request is taken at a time; req.ready is high only while the
// sequencer is idle. Get and release give one result beat each; flush gives one beat
// per dirty entry, or a single empty beat, with last set on the final one.
// All entries live in one single-port-write memory with a registered read, and one
// evaluation unit looks at one entry per cycle. A lookup streams the filled slots at
// one per cycle and stops at a hit or after the last filled slot. A miss in a full
// cache then runs the clock scan over up to two passes of CACHE_ENTRIES slots, one
// per cycle. A flush reads each filled slot and then evaluates it, one slot at a time.
// Reset empties the cache at once: the fill count goes to zero and no clearing pass is
// needed. If the receiver stalls, the result stays in the output register; a flush
// holds one found entry aside and waits when the next one needs the output.
`include "sector_cache_clock_replacement_defines.svh"

module sector_cache_clock_replacement import scc_pkg::*; #(
	parameter int CACHE_ENTRIES = 64
) (
	input logic         clk,
	input logic         arst_n,
	scc_stream_if.sink   req,
	scc_stream_if.source rsp
);

	localparam int IDX_W  = $clog2(CACHE_ENTRIES);
	localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);
	localparam logic [IDX_W-1:0]  IDX_TOP = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CACHE_ENTRIES);

	fsm_t state_q, state_d;

	req_t req_q;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic              done_q, done_d;
	logic              pass_q, pass_d;
	logic [FILL_W-1:0] fill_q, fill_d;

	entry_t            mem [CACHE_ENTRIES];
	entry_t            mem_rd_q;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              rd_vld_s1;
	logic              rd_en;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;

	rsp_t res_q, res_d;
	rsp_t pend_q, pend_d;
	logic pend_vld_q, pend_vld_d;
	rsp_t out_q, out_d;
	logic out_vld_q;
	logic out_load;

	eval_t ev;
	logic  out_free;
	logic  s1_hit;
	logic  scan_end;
	logic  last_fill;
	logic  is_get;

	scc_entry_eval u_eval (
		.entry      (mem_rd_q),
		.sector     (req_q.sector),
		.mark_dirty (req_q.mark_dirty),
		.ev         (ev)
	);

	assign out_free  = !out_vld_q || rsp.ready;
	assign s1_hit    = rd_vld_s1 && ev.tag_eq;
	assign scan_end  = done_q && !rd_vld_s1;
	assign last_fill = ((FILL_W'(ptr_q) + FILL_W'(1)) == fill_q);
	assign is_get    = (req_q.command == CMD_GET);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.payload.command)
						CMD_GET, CMD_RELEASE: state_d = S_LOOKUP;
						CMD_FLUSH:            state_d = S_FL_RD;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_LOOKUP: begin
				priority if (s1_hit) begin
					state_d = S_RESP;
				end else if (scan_end) begin
					state_d = (is_get && fill_q == FILL_FULL) ? S_CLOCK : S_RESP;
				end else begin
					state_d = S_LOOKUP;
				end
			end
			S_CLOCK: begin
				if ((rd_vld_s1 && !ev.pinned && !mem_rd_q.acc) || scan_end) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_FL_RD: begin
				state_d = done_q ? S_FL_END : S_FL_EV;
			end
			S_FL_EV: begin
				if (!(mem_rd_q.dirty && pend_vld_q && !out_free)) begin
					state_d = S_FL_RD;
				end
			end
			S_FL_END: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath control and register next values.
	always_comb begin
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = rd_idx_s1;
		wr_data    = mem_rd_q;
		ptr_d      = ptr_q;
		done_d     = done_q;
		pass_d     = pass_q;
		fill_d     = fill_q;
		res_d      = res_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;
		out_load   = 1'b0;
		out_d      = res_q;
		req.ready  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				req.ready  = 1'b1;
				ptr_d      = '0;
				pass_d     = 1'b0;
				done_d     = (fill_q == '0);
				pend_vld_d = 1'b0;
			end
			S_LOOKUP: begin
				if (!done_q) begin
					rd_en = 1'b1;
					if (last_fill) begin
						done_d = 1'b1;
					end else begin
						ptr_d = ptr_q + IDX_W'(1);
					end
				end
				priority if (s1_hit) begin
					wr_en      = 1'b1;
					wr_data    = is_get ? ev.get_hit : ev.unpin;
					res_d      = '0;
					res_d.slot = SLOT_W'(rd_idx_s1);
					res_d.hit  = is_get;
					res_d.last = 1'b1;
				end else if (scan_end) begin
					res_d      = '0;
					res_d.last = 1'b1;
					if (!is_get) begin
						res_d.status = STAT_ABSENT;
					end else if (fill_q != FILL_FULL) begin
						wr_en              = 1'b1;
						wr_addr            = IDX_W'(fill_q);
						wr_data            = ev.fresh;
						fill_d             = fill_q + FILL_W'(1);
						res_d.slot         = SLOT_W'(fill_q);
						res_d.fetch_needed = 1'b1;
					end else begin
						ptr_d  = '0;
						pass_d = 1'b0;
						done_d = 1'b0;
					end
				end else begin
				end
			end
			S_CLOCK: begin
				if (!done_q) begin
					rd_en = 1'b1;
					if (ptr_q == IDX_TOP) begin
						ptr_d = '0;
						if (pass_q) begin
							done_d = 1'b1;
						end else begin
							pass_d = 1'b1;
						end
					end else begin
						ptr_d = ptr_q + IDX_W'(1);
					end
				end
				priority if (rd_vld_s1 && !ev.pinned) begin
					wr_en = 1'b1;
					if (mem_rd_q.acc) begin
						wr_data = ev.acc_clr;
					end else begin
						// Victim found: report a dirty old tag and bring the new one in.
						wr_data                  = ev.fresh;
						res_d                    = '0;
						res_d.slot               = SLOT_W'(rd_idx_s1);
						res_d.fetch_needed       = 1'b1;
						res_d.writeback_valid    = mem_rd_q.dirty;
						res_d.writeback_sector   = mem_rd_q.dirty ? mem_rd_q.tag : '0;
						res_d.last               = 1'b1;
					end
				end else if (scan_end) begin
					res_d        = '0;
					res_d.status = STAT_NO_VICTIM;
					res_d.last   = 1'b1;
				end else begin
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = res_q;
				end
			end
			S_FL_RD: begin
				rd_en = !done_q;
			end
			S_FL_EV: begin
				// A found entry waits aside until the next one shows whether it is the last.
				if (!(mem_rd_q.dirty && pend_vld_q && !out_free)) begin
					if (mem_rd_q.dirty) begin
						if (pend_vld_q) begin
							out_load = 1'b1;
							out_d    = pend_q;
						end
						pend_vld_d              = 1'b1;
						pend_d                  = '0;
						pend_d.slot             = SLOT_W'(rd_idx_s1);
						pend_d.writeback_valid  = 1'b1;
						pend_d.writeback_sector = mem_rd_q.tag;
						wr_en                   = 1'b1;
						wr_data                 = ev.dirty_clr;
					end
					if (last_fill) begin
						done_d = 1'b1;
					end else begin
						ptr_d = ptr_q + IDX_W'(1);
					end
				end
			end
			S_FL_END: begin
				if (out_free) begin
					out_load = 1'b1;
					if (pend_vld_q) begin
						out_d = pend_q;
					end else begin
						out_d = '0;
					end
					out_d.last = 1'b1;
					pend_vld_d = 1'b0;
					if (req_q.invalidate_all) begin
						fill_d = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ptr_q      <= '0;
			done_q     <= 1'b0;
			pass_q     <= 1'b0;
			fill_q     <= '0;
			rd_vld_s1  <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			ptr_q      <= ptr_d;
			done_q     <= done_d;
			pass_q     <= pass_d;
			fill_q     <= fill_d;
			rd_vld_s1  <= rd_en;
			pend_vld_q <= pend_vld_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.payload;
		end
		res_q  <= res_d;
		pend_q <= pend_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q  <= mem[ptr_q];
			rd_idx_s1 <= ptr_q;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	`SCC_ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_FULL, "fill count above cache size")
	`SCC_ASSERT_IMPLY(a_wr_in_fill, wr_en, FILL_W'(wr_addr) <= fill_q, "write beyond fill point")
	`SCC_ASSERT_IMPLY(a_rd_in_fill, rd_vld_s1, FILL_W'(rd_idx_s1) < fill_q, "read of unfilled slot")

endmodule
